// ===== design/lfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types, register map and phase codes for the line follow sequencer.
// ----------------------------------------------------------------------------
package lfs_pkg;

	// Configuration port geometry.
	localparam int unsigned CfgAddrWidth = 5;
	localparam int unsigned CfgDataWidth = 32;

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_THRESHOLD_LEFT  = 3'd0;
	localparam logic [2:0] REG_THRESHOLD_RIGHT = 3'd1;
	localparam logic [2:0] REG_LEFT_FWD_SET    = 3'd2;
	localparam logic [2:0] REG_RIGHT_FWD_SET   = 3'd3;
	localparam logic [2:0] REG_LEFT_REV_SET    = 3'd4;
	localparam logic [2:0] REG_RIGHT_REV_SET   = 3'd5;
	localparam logic [2:0] REG_SEEK_AT_START   = 3'd6;
	localparam logic [2:0] REG_SPIN_LIMIT      = 3'd7;

	localparam logic [15:0] SPIN_LIMIT_RESET = 16'd500;

	// Brake duration in ticks.
	localparam logic [7:0] BRAKE_TICKS = 8'd1;

	// Phase codes.
	localparam logic [3:0] PH_SEEK    = 4'd0;
	localparam logic [3:0] PH_RCHECK  = 4'd1;
	localparam logic [3:0] PH_RPIVOT  = 4'd2;
	localparam logic [3:0] PH_RBRAKE  = 4'd3;
	localparam logic [3:0] PH_RSPIN   = 4'd4;
	localparam logic [3:0] PH_LCHECK  = 4'd5;
	localparam logic [3:0] PH_LPIVOT  = 4'd6;
	localparam logic [3:0] PH_LBRAKE  = 4'd7;
	localparam logic [3:0] PH_LSPIN   = 4'd8;
	localparam logic [3:0] PH_FORWARD = 4'd9;

	// Wheel enable bit positions.
	localparam int unsigned EN_LF = 0;
	localparam int unsigned EN_LR = 1;
	localparam int unsigned EN_RF = 2;
	localparam int unsigned EN_RR = 3;

	// Reciprocal of three for a 16-bit dividend: q = (x * RECIP3) >> 17.
	localparam logic [16:0] RECIP3 = 17'h0AAAB;

	typedef struct packed {
		logic [9:0] left_sample;
		logic [9:0] right_sample;
		logic       tick;
	} in_item_t;

	typedef struct packed {
		logic [15:0] left_fwd_duty;
		logic [15:0] left_rev_duty;
		logic [15:0] right_fwd_duty;
		logic [15:0] right_rev_duty;
		logic [3:0]  phase_code;
	} out_item_t;

	typedef struct packed {
		logic [9:0]  threshold_left;
		logic [9:0]  threshold_right;
		logic [15:0] left_forward_duty_set;
		logic [15:0] right_forward_duty_set;
		logic [15:0] left_reverse_duty_set;
		logic [15:0] right_reverse_duty_set;
		logic        seek_at_start;
		logic [15:0] spin_limit;
	} cfg_t;

endpackage

// ===== design/lfs_regs.sv =====
// ----------------------------------------------------------------------------
// lfs_regs
// APB-style configuration register file for the line follow sequencer.
// ----------------------------------------------------------------------------
module lfs_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lfs_pkg::CfgAddrWidth-1:0]   paddr,
	input  logic [lfs_pkg::CfgDataWidth-1:0]   pwdata,
	output logic [lfs_pkg::CfgDataWidth-1:0]   prdata,
	output logic                               pready,
	output lfs_pkg::cfg_t                      cfg
);
	import lfs_pkg::*;

	logic       wr_en;
	logic [2:0] reg_idx;
	cfg_t       cfg_q;

	// The port never inserts wait states.
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];

	// Register writes on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_left         <= '0;
			cfg_q.threshold_right        <= '0;
			cfg_q.left_forward_duty_set  <= '0;
			cfg_q.right_forward_duty_set <= '0;
			cfg_q.left_reverse_duty_set  <= '0;
			cfg_q.right_reverse_duty_set <= '0;
			cfg_q.seek_at_start          <= 1'b0;
			cfg_q.spin_limit             <= SPIN_LIMIT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_THRESHOLD_LEFT:  cfg_q.threshold_left         <= pwdata[9:0];
				REG_THRESHOLD_RIGHT: cfg_q.threshold_right        <= pwdata[9:0];
				REG_LEFT_FWD_SET:    cfg_q.left_forward_duty_set  <= pwdata[15:0];
				REG_RIGHT_FWD_SET:   cfg_q.right_forward_duty_set <= pwdata[15:0];
				REG_LEFT_REV_SET:    cfg_q.left_reverse_duty_set  <= pwdata[15:0];
				REG_RIGHT_REV_SET:   cfg_q.right_reverse_duty_set <= pwdata[15:0];
				REG_SEEK_AT_START:   cfg_q.seek_at_start          <= pwdata[0];
				REG_SPIN_LIMIT:      cfg_q.spin_limit             <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		case (reg_idx)
			REG_THRESHOLD_LEFT:  prdata = {22'd0, cfg_q.threshold_left};
			REG_THRESHOLD_RIGHT: prdata = {22'd0, cfg_q.threshold_right};
			REG_LEFT_FWD_SET:    prdata = {16'd0, cfg_q.left_forward_duty_set};
			REG_RIGHT_FWD_SET:   prdata = {16'd0, cfg_q.right_forward_duty_set};
			REG_LEFT_REV_SET:    prdata = {16'd0, cfg_q.left_reverse_duty_set};
			REG_RIGHT_REV_SET:   prdata = {16'd0, cfg_q.right_reverse_duty_set};
			REG_SEEK_AT_START:   prdata = {31'd0, cfg_q.seek_at_start};
			REG_SPIN_LIMIT:      prdata = {16'd0, cfg_q.spin_limit};
			default:             prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== design/lfs_core.sv =====
// ----------------------------------------------------------------------------
// lfs_core
// Sequencer state and the combinational phase step for one sensor sample.
// ----------------------------------------------------------------------------
module lfs_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  lfs_pkg::in_item_t  item,
	input  lfs_pkg::cfg_t      cfg,
	output lfs_pkg::out_item_t result
);
	import lfs_pkg::*;

	// Architectural state.
	logic [3:0]  phase_q;
	logic        first_pass_q;
	logic        rcor_q;
	logic        lcor_q;
	logic [15:0] elapsed_q;
	logic [15:0] target_q;
	logic [7:0]  brake_q;
	logic [3:0]  en_q;

	// Next-state values.
	logic [3:0]  phase_d;
	logic        first_pass_d;
	logic        rcor_d;
	logic        lcor_d;
	logic [15:0] elapsed_d;
	logic [15:0] target_d;
	logic [7:0]  brake_d;
	logic [3:0]  en_d;

	logic        on_l;
	logic        on_r;
	logic        in_brake;
	logic [15:0] elapsed_t;
	logic [7:0]  brake_t;
	logic [32:0] div_prod;
	logic [15:0] third;
	logic        spin_go;

	assign on_l     = item.left_sample >= cfg.threshold_left;
	assign on_r     = item.right_sample >= cfg.threshold_right;
	assign in_brake = (phase_q == PH_RBRAKE) || (phase_q == PH_LBRAKE);

	// Saturating tick counters, advanced before the phase decision.
	assign elapsed_t = (item.tick && (elapsed_q != 16'hFFFF)) ? elapsed_q + 16'd1 : elapsed_q;
	assign brake_t   = (item.tick && in_brake && (brake_q != 8'hFF)) ? brake_q + 8'd1 : brake_q;

	// Elapsed ticks divided by three through a reciprocal multiply.
	assign div_prod = {17'd0, elapsed_t} * {16'd0, RECIP3};
	assign third    = div_prod[32:17];

	// Counter-spin keeps going while below the target and within the limit.
	assign spin_go = (elapsed_t < target_q) && (elapsed_t <= cfg.spin_limit);

	// Phase transition for one sample.
	always_comb begin
		phase_d      = phase_q;
		first_pass_d = first_pass_q;
		rcor_d       = rcor_q;
		lcor_d       = lcor_q;
		elapsed_d    = elapsed_t;
		target_d     = target_q;
		brake_d      = brake_t;
		en_d         = en_q;
		case (phase_q)
			PH_SEEK: begin
				if (on_l || on_r) begin
					en_d[EN_LF] = 1'b0;
					en_d[EN_RF] = 1'b0;
					elapsed_d   = '0;
					phase_d     = PH_RCHECK;
				end
			end
			PH_RPIVOT: begin
				if (on_r) begin
					en_d[EN_RF] = 1'b0;
					en_d[EN_RR] = 1'b1;
					brake_d     = '0;
					phase_d     = PH_RBRAKE;
				end
			end
			PH_RBRAKE: begin
				if (brake_t >= BRAKE_TICKS) begin
					en_d[EN_RR] = 1'b0;
					rcor_d      = 1'b1;
					phase_d     = PH_RCHECK;
				end
			end
			PH_RSPIN: begin
				if (!spin_go) begin
					en_d[EN_RR] = 1'b0;
					en_d[EN_LF] = 1'b0;
					elapsed_d   = '0;
					phase_d     = PH_LCHECK;
				end
			end
			PH_LCHECK: begin
				if (!on_l) begin
					en_d[EN_RF] = 1'b0;
					en_d[EN_LF] = 1'b1;
					phase_d     = PH_LPIVOT;
				end else begin
					target_d = third;
					if (lcor_q) begin
						en_d[EN_RF] = 1'b1;
						en_d[EN_LR] = 1'b1;
						elapsed_d   = '0;
						phase_d     = PH_LSPIN;
					end else begin
						phase_d = PH_FORWARD;
					end
				end
			end
			PH_LPIVOT: begin
				if (on_l) begin
					en_d[EN_LF] = 1'b0;
					en_d[EN_LR] = 1'b1;
					brake_d     = '0;
					phase_d     = PH_LBRAKE;
				end
			end
			PH_LBRAKE: begin
				if (brake_t >= BRAKE_TICKS) begin
					en_d[EN_LR] = 1'b0;
					lcor_d      = 1'b1;
					phase_d     = PH_LCHECK;
				end
			end
			PH_LSPIN: begin
				if (!spin_go) begin
					en_d[EN_LR] = 1'b0;
					en_d[EN_RF] = 1'b0;
					phase_d     = PH_FORWARD;
				end
			end
			PH_FORWARD: begin
				if (on_l && on_r) begin
					en_d[EN_LF] = 1'b1;
					en_d[EN_RF] = 1'b1;
				end else begin
					elapsed_d = '0;
					rcor_d    = 1'b0;
					lcor_d    = 1'b0;
					phase_d   = PH_RCHECK;
				end
			end
			default: begin
				// Right check; unused codes behave the same way.
				if (first_pass_q && cfg.seek_at_start) begin
					first_pass_d = 1'b0;
					en_d[EN_LF]  = 1'b1;
					en_d[EN_RF]  = 1'b1;
					phase_d      = PH_SEEK;
				end else begin
					first_pass_d = 1'b0;
					if (!on_r) begin
						en_d[EN_LF] = 1'b0;
						en_d[EN_RF] = 1'b1;
						phase_d     = PH_RPIVOT;
					end else begin
						target_d  = third;
						elapsed_d = '0;
						if (rcor_q) begin
							en_d[EN_LF] = 1'b1;
							en_d[EN_RR] = 1'b1;
							phase_d     = PH_RSPIN;
						end else begin
							phase_d = PH_LCHECK;
						end
					end
				end
			end
		endcase
	end

	// State update once per accepted sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_RCHECK;
			first_pass_q <= 1'b1;
			rcor_q       <= 1'b0;
			lcor_q       <= 1'b0;
			elapsed_q    <= '0;
			target_q     <= '0;
			brake_q      <= '0;
			en_q         <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			first_pass_q <= first_pass_d;
			rcor_q       <= rcor_d;
			lcor_q       <= lcor_d;
			elapsed_q    <= elapsed_d;
			target_q     <= target_d;
			brake_q      <= brake_d;
			en_q         <= en_d;
		end
	end

	// Duty outputs: a direction drives only when its opposite is off.
	always_comb begin
		result.left_fwd_duty  = (en_d[EN_LF] && !en_d[EN_LR]) ? cfg.left_forward_duty_set  : '0;
		result.left_rev_duty  = (en_d[EN_LR] && !en_d[EN_LF]) ? cfg.left_reverse_duty_set  : '0;
		result.right_fwd_duty = (en_d[EN_RF] && !en_d[EN_RR]) ? cfg.right_forward_duty_set : '0;
		result.right_rev_duty = (en_d[EN_RR] && !en_d[EN_RF]) ? cfg.right_reverse_duty_set : '0;
		result.phase_code     = phase_d;
	end

endmodule

// ===== design/line_follow_sequencer.sv =====
// ----------------------------------------------------------------------------
// line_follow_sequencer
// Line-following wheel sequencer: sensor samples in, four wheel duties out.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat carries a left and right line-sensor sample and a tick
// flag; each beat produces exactly one output beat with the four wheel PWM
// compare values and the phase code after the step.
// The input beat is captured in an input register, the phase step runs in
// combinational logic, and the result lands in an output register. One beat
// is accepted every cycle while in_stall is low; the rate is set by the
// state update loop in the core.
// When the receiver stalls, the output register holds its beat and the
// input register keeps one more; in_stall rises only when both are full.
// Reset clears the sequencer to the right check phase with the first-pass
// flag set and all wheels off; configuration registers take their defaults
// (spin limit 500, all others zero). The user must write registers through
// the APB port only while no beats are in flight; the block does not check.
// ----------------------------------------------------------------------------
module line_follow_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  lfs_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output lfs_pkg::out_item_t                out_data,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lfs_pkg::CfgAddrWidth-1:0]  paddr,
	input  logic [lfs_pkg::CfgDataWidth-1:0]  pwdata,
	output logic [lfs_pkg::CfgDataWidth-1:0]  prdata,
	output logic                              pready
);
	import lfs_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t result_s2;
	logic      valid_s2;
	logic      out_free;
	logic      step;

	// Configuration registers.
	lfs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Flow control: the step fires when the output register can take a beat.
	assign out_free = !valid_s2 || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Sequencer state and phase step.
	lfs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

// ===== bench/line_follow_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// line_follow_sequencer_test
// Self-checking bench for the line follow sequencer.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the sequencer state and of the
// register set. It predicts the four wheel duties and the phase code of every
// accepted input beat and compares each output beat against the oldest
// prediction. Stimulus starts with a short walk through the seek, pivot,
// brake, counter-spin and forward phases. It then moves to runs of held
// sensor levels with random content and some noise, under several register
// settings. One long pivot keeps the block parked with every beat ticking.
// Both handshake sides idle at random, and there is one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module line_follow_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lfs_pkg::*;

	// Cycles without any accepted beat or register access before giving up.
	localparam int unsigned STUCK_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned MAX_REPORTS = 10;

	// Predicts the wheel duties and phase of each beat and holds them in order.
	class wheel_scoreboard;
		cfg_t        regs;
		logic [3:0]  phase;
		bit          first_pass;
		bit          right_corrected;
		bit          left_corrected;
		logic [15:0] elapsed;
		logic [15:0] spin_target;
		logic [7:0]  brake_count;
		logic [3:0]  enables;
		out_item_t   expected_duties[$];
		int unsigned mismatches;
		int unsigned samples_seen;
		int unsigned results_checked;
		bit [15:0]   phases_seen;

		function new();
			regs = '0;
			regs.spin_limit = SPIN_LIMIT_RESET;
			phase = PH_RCHECK;
			first_pass = 1'b1;
			right_corrected = 1'b0;
			left_corrected = 1'b0;
			elapsed = '0;
			spin_target = '0;
			brake_count = '0;
			enables = '0;
			mismatches = 0;
			samples_seen = 0;
			results_checked = 0;
			phases_seen = '0;
		endfunction

		// Register writes keep only the bits that the register holds.
		function void write_register(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_THRESHOLD_LEFT:  regs.threshold_left = value[9:0];
				REG_THRESHOLD_RIGHT: regs.threshold_right = value[9:0];
				REG_LEFT_FWD_SET:    regs.left_forward_duty_set = value[15:0];
				REG_RIGHT_FWD_SET:   regs.right_forward_duty_set = value[15:0];
				REG_LEFT_REV_SET:    regs.left_reverse_duty_set = value[15:0];
				REG_RIGHT_REV_SET:   regs.right_reverse_duty_set = value[15:0];
				REG_SEEK_AT_START:   regs.seek_at_start = value[0];
				default:             regs.spin_limit = value[15:0];
			endcase
		endfunction

		// A direction is driven only while the opposite one of its wheel is off.
		function logic [15:0] drive(bit mine, bit other, logic [15:0] duty_set);
			return (mine && !other) ? duty_set : 16'd0;
		endfunction

		function int unsigned pending();
			return expected_duties.size();
		endfunction

		// Advances the sequencer by one accepted sample beat.
		function void note_sample(in_item_t item);
			bit        on_l;
			bit        on_r;
			bit        seek_now;
			out_item_t res;
			on_l = item.left_sample >= regs.threshold_left;
			on_r = item.right_sample >= regs.threshold_right;
			seek_now = 1'b0;
			samples_seen++;

			// Both counters saturate.
			if (item.tick) begin
				if (elapsed != 16'hFFFF)
					elapsed = elapsed + 16'd1;
				if ((phase == PH_RBRAKE || phase == PH_LBRAKE) && brake_count != 8'hFF)
					brake_count = brake_count + 8'd1;
			end

			case (phase)
				PH_SEEK: begin
					if (on_l || on_r) begin
						enables[EN_LF] = 1'b0;
						enables[EN_RF] = 1'b0;
						elapsed = '0;
						phase = PH_RCHECK;
					end
				end
				PH_RPIVOT: begin
					if (on_r) begin
						enables[EN_RF] = 1'b0;
						enables[EN_RR] = 1'b1;
						brake_count = '0;
						phase = PH_RBRAKE;
					end
				end
				PH_RBRAKE: begin
					if (brake_count >= BRAKE_TICKS) begin
						enables[EN_RR] = 1'b0;
						right_corrected = 1'b1;
						phase = PH_RCHECK;
					end
				end
				PH_RSPIN: begin
					if (!(elapsed < spin_target && elapsed <= regs.spin_limit)) begin
						enables[EN_RR] = 1'b0;
						enables[EN_LF] = 1'b0;
						elapsed = '0;
						phase = PH_LCHECK;
					end
				end
				PH_LCHECK: begin
					if (!on_l) begin
						enables[EN_RF] = 1'b0;
						enables[EN_LF] = 1'b1;
						phase = PH_LPIVOT;
					end else begin
						spin_target = elapsed / 16'd3;
						if (left_corrected) begin
							enables[EN_RF] = 1'b1;
							enables[EN_LR] = 1'b1;
							elapsed = '0;
							phase = PH_LSPIN;
						end else begin
							phase = PH_FORWARD;
						end
					end
				end
				PH_LPIVOT: begin
					if (on_l) begin
						enables[EN_LF] = 1'b0;
						enables[EN_LR] = 1'b1;
						brake_count = '0;
						phase = PH_LBRAKE;
					end
				end
				PH_LBRAKE: begin
					if (brake_count >= BRAKE_TICKS) begin
						enables[EN_LR] = 1'b0;
						left_corrected = 1'b1;
						phase = PH_LCHECK;
					end
				end
				PH_LSPIN: begin
					if (!(elapsed < spin_target && elapsed <= regs.spin_limit)) begin
						enables[EN_LR] = 1'b0;
						enables[EN_RF] = 1'b0;
						phase = PH_FORWARD;
					end
				end
				PH_FORWARD: begin
					if (on_l && on_r) begin
						enables[EN_LF] = 1'b1;
						enables[EN_RF] = 1'b1;
					end else begin
						elapsed = '0;
						right_corrected = 1'b0;
						left_corrected = 1'b0;
						phase = PH_RCHECK;
					end
				end
				default: begin
					// Right check; the very first one may divert into seek.
					if (first_pass) begin
						first_pass = 1'b0;
						if (regs.seek_at_start) begin
							enables[EN_LF] = 1'b1;
							enables[EN_RF] = 1'b1;
							phase = PH_SEEK;
							seek_now = 1'b1;
						end
					end
					if (!seek_now) begin
						if (!on_r) begin
							enables[EN_LF] = 1'b0;
							enables[EN_RF] = 1'b1;
							phase = PH_RPIVOT;
						end else begin
							spin_target = elapsed / 16'd3;
							elapsed = '0;
							if (right_corrected) begin
								enables[EN_LF] = 1'b1;
								enables[EN_RR] = 1'b1;
								phase = PH_RSPIN;
							end else begin
								phase = PH_LCHECK;
							end
						end
					end
				end
			endcase

			res.left_fwd_duty = drive(enables[EN_LF], enables[EN_LR],
				regs.left_forward_duty_set);
			res.left_rev_duty = drive(enables[EN_LR], enables[EN_LF],
				regs.left_reverse_duty_set);
			res.right_fwd_duty = drive(enables[EN_RF], enables[EN_RR],
				regs.right_forward_duty_set);
			res.right_rev_duty = drive(enables[EN_RR], enables[EN_RF],
				regs.right_reverse_duty_set);
			res.phase_code = phase;
			phases_seen[phase] = 1'b1;
			expected_duties.push_back(res);
		endfunction

		// Compares one output beat with the oldest prediction.
		function void check_duties(out_item_t got);
			out_item_t want;
			bit        bad;
			results_checked++;
			if (expected_duties.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("output beat with nothing predicted: %p", got);
				return;
			end
			want = expected_duties.pop_front();
			bad = (got.left_fwd_duty !== want.left_fwd_duty)
				|| (got.left_rev_duty !== want.left_rev_duty)
				|| (got.right_fwd_duty !== want.right_fwd_duty)
				|| (got.right_rev_duty !== want.right_rev_duty)
				|| (got.phase_code !== want.phase_code);
			if (bad) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch at result %0d: expected %p, got %p",
						results_checked, want, got);
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      psel;
	logic      penable;
	logic      pwrite;
	logic [CfgAddrWidth-1:0] paddr;
	logic [CfgDataWidth-1:0] pwdata;
	logic [CfgDataWidth-1:0] prdata;
	logic      pready;

	wheel_scoreboard board = new();
	bit          no_idle = 1'b0;
	bit          hold_request = 1'b0;
	int unsigned idle_cycles;

	line_follow_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// Every accepted beat in either direction goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_sample(in_data);
			if (out_valid && !out_stall)
				board.check_duties(out_data);
		end
	end

	// Receiver: a random hold-off before each beat, one long one on request.
	initial begin : receiver
		int unsigned wait_cycles;
		out_stall <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				wait_cycles = HOLD_CYCLES;
			end else begin
				wait_cycles = no_idle ? 0 : $urandom_range(0, 4);
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	initial begin : watchdog
		idle_cycles = 0;
		while (idle_cycles < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no beat accepted for %0d cycles", STUCK_LIMIT);
		$display("status: fail");
		$finish;
	end

	function automatic in_item_t beat(int unsigned left, int unsigned right, bit tick);
		in_item_t item;
		item.left_sample = left[9:0];
		item.right_sample = right[9:0];
		item.tick = tick;
		return item;
	endfunction

	// Offers one input beat after a random gap and returns once it is taken.
	task automatic send_beat(in_item_t item);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
	endtask

	// Stops offering beats and waits until every prediction is matched.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup phase, then access phase until pready. Bits above the
	// register width carry random garbage that the block must drop.
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		int unsigned width;
		case (idx)
			REG_THRESHOLD_LEFT, REG_THRESHOLD_RIGHT: width = 10;
			REG_SEEK_AT_START: width = 1;
			default: width = 16;
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= (value & ((32'd1 << width) - 32'd1)) | ($urandom << width);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		board.write_register(idx, value);
	endtask

	task automatic apply_settings(int unsigned thr_l, int unsigned thr_r,
			int unsigned lf, int unsigned rf, int unsigned lr, int unsigned rr,
			bit seek, int unsigned limit);
		write_reg(REG_THRESHOLD_LEFT, thr_l);
		write_reg(REG_THRESHOLD_RIGHT, thr_r);
		write_reg(REG_LEFT_FWD_SET, lf);
		write_reg(REG_RIGHT_FWD_SET, rf);
		write_reg(REG_LEFT_REV_SET, lr);
		write_reg(REG_RIGHT_REV_SET, rr);
		write_reg(REG_SEEK_AT_START, 32'(seek));
		write_reg(REG_SPIN_LIMIT, limit);
	endtask

	// Sample value on the requested side of a threshold.
	function automatic int unsigned level_sample(bit on_line, logic [9:0] thr);
		if (on_line || thr == 0)
			return $urandom_range(thr, 1023);
		return $urandom_range(0, thr - 1);
	endfunction

	// Held sensor levels of random length, with a per-stretch tick rate and
	// about one beat in ten of pure noise.
	task automatic run_pattern(int unsigned count);
		bit          want_l;
		bit          want_r;
		int unsigned hold_l;
		int unsigned hold_r;
		int unsigned tick_pct;
		in_item_t    item;
		hold_l = 0;
		hold_r = 0;
		tick_pct = 50;
		for (int unsigned k = 0; k < count; k++) begin
			if (k % 64 == 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
				tick_pct = $urandom_range(0, 100);
			end
			if (hold_l == 0) begin
				want_l = 1'($urandom_range(0, 1));
				hold_l = $urandom_range(1, 24);
			end
			if (hold_r == 0) begin
				want_r = 1'($urandom_range(0, 1));
				hold_r = $urandom_range(1, 24);
			end
			hold_l--;
			hold_r--;
			if ($urandom_range(0, 9) == 0) begin
				item = beat($urandom_range(0, 1023), $urandom_range(0, 1023),
					1'($urandom_range(0, 1)));
			end else begin
				item = beat(level_sample(want_l, board.regs.threshold_left),
					level_sample(want_r, board.regs.threshold_right),
					$urandom_range(0, 99) < tick_pct);
			end
			send_beat(item);
		end
		no_idle = 1'b0;
	endtask

	initial begin : stimulus
		in_valid <= 1'b0;
		in_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Mid thresholds with seek on, so the first beat enters seek.
		apply_settings(512, 512, $urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535), 1'b1, 500);

		// Directed walk: seek, right pivot and brake, counter-spin, left
		// side, forward, forward exit; thresholds hit exactly and missed by one.
		send_beat(beat(0, 0, 1'b1));
		send_beat(beat(0, 0, 1'b1));
		send_beat(beat(1023, 0, 1'b0));
		send_beat(beat(1023, 511, 1'b1));
		send_beat(beat(0, 0, 1'b1));
		send_beat(beat(0, 0, 1'b1));
		send_beat(beat(0, 0, 1'b1));
		send_beat(beat(0, 512, 1'b0));
		send_beat(beat(1023, 1023, 1'b0));
		send_beat(beat(1023, 1023, 1'b1));
		send_beat(beat(1023, 1023, 1'b0));
		send_beat(beat(1023, 1023, 1'b1));
		send_beat(beat(1023, 1023, 1'b1));
		send_beat(beat(511, 1023, 1'b1));
		send_beat(beat(0, 1023, 1'b1));
		send_beat(beat(512, 0, 1'b1));
		send_beat(beat(1023, 1023, 1'b1));
		send_beat(beat(1023, 1023, 1'b0));
		send_beat(beat(1023, 1023, 1'b1));
		send_beat(beat(1023, 1023, 1'b1));
		send_beat(beat(1023, 1023, 1'b0));
		send_beat(beat(1023, 0, 1'b1));

		// Random stretch with a long receiver hold-off and a full sender pause.
		run_pattern(200);
		hold_request = 1'b1;
		run_pattern(200);
		drain();
		run_pattern(200);
		drain();

		// Extremes: left always on, right only at full scale, spin limit of zero.
		apply_settings(0, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0);
		run_pattern(300);
		drain();

		apply_settings(1023, 0, 0, 0, 0, 0, 1'b1, 16'hFFFF);
		run_pattern(300);
		drain();

		apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535),
			1'($urandom_range(0, 1)), 2);
		run_pattern(300);
		drain();

		// Right never sees the line: the block parks in right pivot while every
		// beat ticks and the elapsed tick count keeps growing.
		apply_settings(0, 1023, $urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535), 1'b0, 500);
		no_idle = 1'b1;
		for (int unsigned k = 0; k < 100; k++)
			send_beat(beat($urandom_range(0, 1023), $urandom_range(0, 1022), 1'b1));
		send_beat(beat(1023, 1023, 1'b1));
		no_idle = 1'b0;
		drain();

		apply_settings($urandom_range(300, 700), $urandom_range(300, 700),
			$urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535),
			1'($urandom_range(0, 1)), $urandom_range(0, 40));
		run_pattern(230);
		drain();

		$display("run covered %0d sample beats and %0d results over %0d distinct phases",
			board.samples_seen, board.results_checked, $countones(board.phases_seen));
		$display("mismatches %0d, predictions left over %0d",
			board.mismatches, board.pending());
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
